// ===== rtl/pointer_hash_set_linear_probe_macros.svh =====
// assertion macros for the checker file
`ifndef POINTER_HASH_SET_LINEAR_PROBE_MACROS_SVH
`define POINTER_HASH_SET_LINEAR_PROBE_MACROS_SVH

// clocked assertion, masked while reset is held
`define PHS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds across reset
`define PHS_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/phs_pkg.sv =====
// shared types, constants and codes of the pointer hash set
package phs_pkg;

    localparam int KEY_W           = 64;
    localparam int TABLE_SLOTS_DEF = 1024;
    localparam int CACHE_SLOTS_DEF = 256;

    localparam int MAX_ENTRIES_W   = 10;
    localparam logic [MAX_ENTRIES_W-1:0] MAX_ENTRIES_RST = 10'd716;

    localparam logic [KEY_W-1:0] MIX_MULT    = 64'hff51afd7ed558ccd;
    localparam logic [31:0]      MIX_MULT_LO = MIX_MULT[31:0];
    localparam logic [31:0]      MIX_MULT_HI = MIX_MULT[63:32];
    localparam int               MIX_SHIFT   = 33;
    localparam int               ALIGN_SHIFT = 3;

    // operation codes
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_PRESENT = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;
    localparam logic [1:0] STATUS_ZERO    = 2'd3;

    typedef struct packed {
        logic [1:0]       func;
        logic [KEY_W-1:0] key;
    } phs_in_t;

    typedef struct packed {
        logic       found;
        logic [1:0] status;
    } phs_out_t;

endpackage

// ===== rtl/phs_ram.sv =====
// generic single-write, single-read ram with registered read data
module phs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/phs_hash.sv =====
// home slot hash: premix, 64-bit multiply over one shared 32x32 multiplier, final xor-shift
module phs_hash #(
    parameter int TABLE_SLOTS = phs_pkg::TABLE_SLOTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [phs_pkg::KEY_W-1:0]      key,
    output logic                           done,
    output logic [$clog2(TABLE_SLOTS)-1:0] idx
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);

    localparam logic [1:0] PH_LOLO = 2'd0;
    localparam logic [1:0] PH_HILO = 2'd1;
    localparam logic [1:0] PH_LOHI = 2'd2;
    localparam logic [1:0] PH_FIN  = 2'd3;

    logic                      busy_reg;
    logic [1:0]                phase_reg;
    logic [phs_pkg::KEY_W-1:0] x_reg;
    logic [phs_pkg::KEY_W-1:0] acc_reg;
    logic [31:0]               cross_reg;
    logic                      done_reg;
    logic [IDX_W-1:0]          idx_reg;

    logic [phs_pkg::KEY_W-1:0] x_shr;
    logic [31:0]               mul_a;
    logic [31:0]               mul_b;
    logic [63:0]               prod;
    logic [phs_pkg::KEY_W-1:0] h;
    logic [phs_pkg::KEY_W-1:0] f;

    assign x_shr = key >> phs_pkg::ALIGN_SHIFT;

    // one multiplier, operands picked by phase
    assign mul_a = (phase_reg == PH_HILO) ? x_reg[63:32] : x_reg[31:0];
    assign mul_b = (phase_reg == PH_LOHI) ? phs_pkg::MIX_MULT_HI : phs_pkg::MIX_MULT_LO;
    assign prod  = mul_a * mul_b;

    // only the low half of the cross terms lands below bit 64
    assign h = acc_reg + {cross_reg, 32'd0};
    assign f = h ^ (h >> phs_pkg::MIX_SHIFT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= PH_LOLO;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                phase_reg <= PH_LOLO;
            end else if (busy_reg) begin
                phase_reg <= phase_reg + 2'd1;
                if (phase_reg == PH_FIN) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= x_shr ^ (x_shr >> phs_pkg::MIX_SHIFT);
        end
        if (busy_reg && !start) begin
            unique case (phase_reg)
                PH_LOLO: begin
                    acc_reg <= prod;
                end
                PH_HILO: begin
                    cross_reg <= prod[31:0];
                end
                PH_LOHI: begin
                    cross_reg <= cross_reg + prod[31:0];
                end
                PH_FIN: begin
                    idx_reg <= f[IDX_W-1:0];
                end
                default: begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign idx  = idx_reg;

endmodule

// ===== rtl/pointer_hash_set_linear_probe.sv =====
// pointer hash set: open-addressing table with linear probing and a direct-mapped front cache
//
// channels: s_ takes one item (func, key) per transfer; m_ returns one result
// (found, status) per item, in order. cfg_ writes max_entries at any transfer
// and is always ready; write it only while the set is idle.
// flow: one item is in work at a time; s_ready rises at the
// edge that loads the result, so a new item is taken only once the last one's result is loaded.
//   insert, or lookup that misses the front cache: the hash unit's shared
//   32x32 multiplier makes three passes and a final step gives the home slot,
//   whose table read decides the result or starts a walk slot by slot to an
//   empty slot or a hit; the hash wait takes most of the time per item.
//   lookup that hits the front cache skips the hash wait; zero key and unused func go straight to the result.
//   clear: a pass over max(TABLE_SLOTS, CACHE_SLOTS) rows, one ram row per cycle.
// reset: a clearing pass over max(TABLE_SLOTS, CACHE_SLOTS) rows zeroes both
// memories (1024 rows at the defaults) with s_ready low; cfg writes are still
// taken. max_entries returns to 716.
// stall: the result sits in an output register; the next item is accepted
// while it waits, and that item's result waits for the register to drain.
module pointer_hash_set_linear_probe #(
    parameter int TABLE_SLOTS = phs_pkg::TABLE_SLOTS_DEF,
    parameter int CACHE_SLOTS = phs_pkg::CACHE_SLOTS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // item input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  phs_pkg::phs_in_t                  s_data,
    // result output
    output logic                              m_valid,
    input  logic                              m_ready,
    output phs_pkg::phs_out_t                 m_data,
    // max_entries register write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [phs_pkg::MAX_ENTRIES_W-1:0] cfg_data
);

    localparam int IDX_W   = $clog2(TABLE_SLOTS);
    localparam int CACHE_W = $clog2(CACHE_SLOTS);
    localparam int SWEEP   = (TABLE_SLOTS > CACHE_SLOTS) ? TABLE_SLOTS : CACHE_SLOTS;
    localparam int SW_W    = $clog2(SWEEP);
    localparam int LIM_W   = (IDX_W > phs_pkg::MAX_ENTRIES_W) ? IDX_W : phs_pkg::MAX_ENTRIES_W;
    localparam int KEY_W   = phs_pkg::KEY_W;

    // control states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CACHE = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_PROBE = 3'd3;
    localparam logic [2:0] ST_CLEAR = 3'd4;
    localparam logic [2:0] ST_RESP  = 3'd5;

    logic [2:0]                        state_reg,       state_next;
    logic [1:0]                        func_reg,        func_next;
    logic [KEY_W-1:0]                  key_reg,         key_next;
    logic [IDX_W-1:0]                  idx_reg,         idx_next;
    logic [IDX_W-1:0]                  key_count_reg,   key_count_next;
    logic [SW_W-1:0]                   clr_cnt_reg,     clr_cnt_next;
    logic                              clr_rsp_reg,     clr_rsp_next;
    phs_pkg::phs_out_t                 res_reg,         res_next;
    logic                              m_valid_reg,     m_valid_next;
    phs_pkg::phs_out_t                 m_data_reg,      m_data_next;
    logic [phs_pkg::MAX_ENTRIES_W-1:0] max_entries_reg, max_entries_next;

    // memory ports
    logic               tbl_we;
    logic [IDX_W-1:0]   tbl_waddr;
    logic [KEY_W-1:0]   tbl_wdata;
    logic [IDX_W-1:0]   tbl_raddr;
    logic [KEY_W-1:0]   tbl_rdata;
    logic               cch_we;
    logic [CACHE_W-1:0] cch_waddr;
    logic [KEY_W-1:0]   cch_wdata;
    logic [CACHE_W-1:0] cch_raddr;
    logic [KEY_W-1:0]   cch_rdata;

    // hash unit
    logic             hash_start;
    logic             hash_done;
    logic [IDX_W-1:0] hash_idx;

    logic [LIM_W-1:0] limit;
    logic             set_full;
    logic             clr_last;
    logic             clr_tbl_en;
    logic             clr_cch_en;

    phs_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_SLOTS)) u_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    phs_ram #(.WIDTH(KEY_W), .DEPTH(CACHE_SLOTS)) u_cache (
        .aclk  (aclk),
        .we    (cch_we),
        .waddr (cch_waddr),
        .wdata (cch_wdata),
        .raddr (cch_raddr),
        .rdata (cch_rdata)
    );

    phs_hash #(.TABLE_SLOTS(TABLE_SLOTS)) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key     (key_next),
        .done    (hash_done),
        .idx     (hash_idx)
    );

    // limit in effect never reaches the slot count, so a probe always ends on an
    // empty slot or a hit
    always_comb begin
        if (LIM_W'(max_entries_reg) > LIM_W'(TABLE_SLOTS - 1)) begin
            limit = LIM_W'(TABLE_SLOTS - 1);
        end else begin
            limit = LIM_W'(max_entries_reg);
        end
    end
    assign set_full = LIM_W'(key_count_reg) >= limit;

    // clearing pass bookkeeping
    assign clr_last   = clr_cnt_reg == SW_W'(SWEEP - 1);
    assign clr_tbl_en = {1'b0, clr_cnt_reg} < (SW_W + 1)'(TABLE_SLOTS);
    assign clr_cch_en = {1'b0, clr_cnt_reg} < (SW_W + 1)'(CACHE_SLOTS);

    assign max_entries_next = cfg_valid ? cfg_data : max_entries_reg;

    always_comb begin
        state_next     = state_reg;
        func_next      = func_reg;
        key_next       = key_reg;
        idx_next       = idx_reg;
        key_count_next = key_count_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_rsp_next   = clr_rsp_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;

        hash_start = 1'b0;
        tbl_we     = 1'b0;
        tbl_waddr  = idx_reg;
        tbl_wdata  = key_reg;
        tbl_raddr  = idx_reg;
        cch_we     = 1'b0;
        cch_waddr  = key_reg[phs_pkg::ALIGN_SHIFT +: CACHE_W];
        cch_wdata  = key_reg;
        cch_raddr  = key_reg[phs_pkg::ALIGN_SHIFT +: CACHE_W];

        unique case (state_reg)
            ST_IDLE: begin
                // front cache read goes out with the transfer
                cch_raddr = s_data.key[phs_pkg::ALIGN_SHIFT +: CACHE_W];
                if (s_valid) begin
                    func_next       = s_data.func;
                    key_next        = s_data.key;
                    res_next.found  = 1'b0;
                    res_next.status = phs_pkg::STATUS_DONE;
                    priority if (s_data.func == phs_pkg::FUNC_CLEAR) begin
                        clr_cnt_next = '0;
                        clr_rsp_next = 1'b1;
                        state_next   = ST_CLEAR;
                    end else if (s_data.func == phs_pkg::FUNC_INSERT ||
                                 s_data.func == phs_pkg::FUNC_LOOKUP) begin
                        if (s_data.key == '0) begin
                            res_next.status = phs_pkg::STATUS_ZERO;
                            state_next      = ST_RESP;
                        end else begin
                            hash_start = 1'b1;
                            state_next = ST_CACHE;
                        end
                    end else begin
                        // unused func: plain done
                        state_next = ST_RESP;
                    end
                end
            end
            ST_CACHE: begin
                if (func_reg == phs_pkg::FUNC_LOOKUP && cch_rdata == key_reg) begin
                    res_next.found  = 1'b1;
                    res_next.status = phs_pkg::STATUS_PRESENT;
                    state_next      = ST_RESP;
                end else begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (hash_done) begin
                    tbl_raddr  = hash_idx;
                    idx_next   = hash_idx;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                priority if (tbl_rdata == '0) begin
                    // empty slot ends the walk: miss
                    if (func_reg == phs_pkg::FUNC_INSERT) begin
                        if (set_full) begin
                            res_next.status = phs_pkg::STATUS_FULL;
                        end else begin
                            tbl_we          = 1'b1;
                            cch_we          = 1'b1;
                            key_count_next  = key_count_reg + IDX_W'(1);
                            res_next.status = phs_pkg::STATUS_DONE;
                        end
                    end
                    state_next = ST_RESP;
                end else if (tbl_rdata == key_reg) begin
                    res_next.found  = 1'b1;
                    res_next.status = phs_pkg::STATUS_PRESENT;
                    // table hit on lookup refills the front cache
                    cch_we          = func_reg == phs_pkg::FUNC_LOOKUP;
                    state_next      = ST_RESP;
                end else begin
                    // step to the next slot, wrapping with the index width
                    idx_next  = idx_reg + IDX_W'(1);
                    tbl_raddr = idx_reg + IDX_W'(1);
                end
            end
            ST_CLEAR: begin
                tbl_we       = clr_tbl_en;
                tbl_waddr    = clr_cnt_reg[IDX_W-1:0];
                tbl_wdata    = '0;
                cch_we       = clr_cch_en;
                cch_waddr    = clr_cnt_reg[CACHE_W-1:0];
                cch_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + SW_W'(1);
                if (clr_last) begin
                    key_count_next = '0;
                    state_next     = clr_rsp_reg ? ST_RESP : ST_IDLE;
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            clr_rsp_reg     <= 1'b0;
            key_count_reg   <= '0;
            m_valid_reg     <= 1'b0;
            max_entries_reg <= phs_pkg::MAX_ENTRIES_RST;
        end else begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            clr_rsp_reg     <= clr_rsp_next;
            key_count_reg   <= key_count_next;
            m_valid_reg     <= m_valid_next;
            max_entries_reg <= max_entries_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        func_reg   <= func_next;
        key_reg    <= key_next;
        idx_reg    <= idx_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready   = state_reg == ST_IDLE;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

endmodule

// ===== rtl/phs_checker.sv =====
// port-level checker of the pointer hash set, bound to the top level
`include "pointer_hash_set_linear_probe_macros.svh"

module phs_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input phs_pkg::phs_out_t m_data
);

    // reset starts the clearing pass, so no item is taken right after it
    `PHS_ASSERT_RST(a_reset_blocks_input, aclk, !aresetn |=> !s_ready, "input ready after reset")

    // one item in work at a time
    `PHS_ASSERT(a_one_item, aclk, aresetn, s_valid && s_ready |=> !s_ready, "second item taken")

    // found and the present status agree on every valid result
    `PHS_ASSERT(a_found_status, aclk, aresetn, m_valid |-> (m_data.found == (m_data.status == phs_pkg::STATUS_PRESENT)), "found and status disagree")

    `PHS_ASSERT(a_m_valid_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid, "result dropped")

    `PHS_ASSERT(a_m_data_hold, aclk, aresetn, m_valid && !m_ready |=> $stable(m_data), "result changed")

endmodule

bind pointer_hash_set_linear_probe phs_checker u_phs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
